@@ src/timer_irq_controller_assert.svh @@
// ---------------------------------------------------------------------------
// timer irq controller assertion macros
// concurrent check wrappers, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef TIMER_IRQ_CONTROLLER_ASSERT_SVH
`define TIMER_IRQ_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TIC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define TIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TIC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TIC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/tic_pkg.sv @@
// ---------------------------------------------------------------------------
// tic_pkg
// op codes, register offsets and constants of the timer irq controller
// ---------------------------------------------------------------------------
package tic_pkg;

   localparam logic [2:0] OP_POLL        = 3'd0;
   localparam logic [2:0] OP_ELAPSE      = 3'd1;
   localparam logic [2:0] OP_TIMER_WRITE = 3'd2;
   localparam logic [2:0] OP_TIMER_READ  = 3'd3;
   localparam logic [2:0] OP_IRQ_WRITE   = 3'd4;
   localparam logic [2:0] OP_IRQ_READ    = 3'd5;
   localparam logic [2:0] OP_LINE        = 3'd6;

   localparam logic [1:0] IRQ_OFS_MASK    = 2'd2;
   localparam logic [1:0] IRQ_OFS_PENDING = 2'd3;

   localparam logic [15:0] VEC_SRC0 = 16'hFFF6;
   localparam logic [15:0] VEC_SRC1 = 16'hFFF8;
   localparam logic [15:0] VEC_SRC2 = 16'hFFFA;

   localparam logic [6:0] LOAD_FIELD_MASK = 7'h7F;
   localparam int         LOAD_SHIFT      = 10;

   localparam int COUNT_W  = 32;
   localparam int RELOAD_W = 18;
   localparam int UNIT_W   = 34;

   localparam logic [1:0] LINE_NONE = 2'd3;

endpackage

@@ src/timer_irq_controller.sv @@
// ---------------------------------------------------------------------------
// timer_irq_controller
// cpu-side countdown timer and three-source interrupt controller
// ---------------------------------------------------------------------------
//
// channel   dir  payload
// --------  ---  -----------------------------------------------------------
// req_*     in   tuser: op; tdata: offset, data, cycles, line, level, imask
// rsp_*     out  tdata: read_data, vector_taken, vector_address
//
// an accepted item runs through exec and done; a poll adds pick, and a poll
// that reloads runs div and fix before pick: the remainder by the reload
// runs one bit a cycle (32 steps) on the one 34-bit subtractor, which also
// does the elapse subtract, the negate and the final reload adjust
// reset is synchronous, active high, clears all timer and irq state
// the next item is taken once the result is in the output register
//
`include "timer_irq_controller_assert.svh"

module timer_irq_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] op
   input  logic [2:0]  req_tuser,
   // [1:0] reg_offset, [9:2] write_data, [29:10] elapsed_cycles,
   // [31:30] line_index, [32] line_level, [33] interrupt_mask, rest zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] vector_taken, [24:9] vector_address, rest zero
   output logic [31:0] rsp_tdata
);

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_PICK = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int CW = tic_pkg::COUNT_W;
   localparam int RW = tic_pkg::RELOAD_W;
   localparam int UW = tic_pkg::UNIT_W;

   logic [2:0]    state_ff, state_in;
   logic [4:0]    step_ff, step_in;

   // architectural state
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] reload_ff, reload_in;
   logic          enable_ff, enable_in;
   logic [2:0]    pending_ff, pending_in;
   logic [7:0]    dmask_ff, dmask_in;

   // latched item
   logic [2:0]    op_ff;
   logic [1:0]    ofs_ff;
   logic [7:0]    wdata_ff;
   logic [19:0]   cyc_ff;
   logic [1:0]    lidx_ff;
   logic          llev_ff;
   logic          imask_ff;

   // remainder datapath
   logic [CW-1:0] dividend_ff, dividend_in;
   logic [RW-1:0] rem_ff, rem_in;

   // result being built and output register
   logic [7:0]    res_rd_ff, res_rd_in;
   logic          res_taken_ff, res_taken_in;
   logic [15:0]   res_vec_ff, res_vec_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_rd_ff;
   logic          out_taken_ff;
   logic [15:0]   out_vec_ff;

   // shared subtractor
   logic [UW-1:0] opa, opb, diff;
   logic [RW:0]   shifted;
   logic [2:0]    live;
   logic          accept, out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign shifted    = {rem_ff, dividend_ff[CW-1]};
   assign live       = pending_ff & ~dmask_ff[2:0];

   // operand select for the one subtractor
   always_comb begin
      opa = '0;
      opb = '0;
      case (state_ff)
         ST_EXEC: begin
            if (op_ff == tic_pkg::OP_ELAPSE) begin
               opa = {{(UW-CW){count_ff[CW-1]}}, count_ff};
               opb = {{(UW-20){1'b0}}, cyc_ff};
            end else begin
               // negate the counter to get the magnitude
               opa = '0;
               opb = {{(UW-CW){count_ff[CW-1]}}, count_ff};
            end
         end
         ST_DIV: begin
            opa = {{(UW-RW-1){1'b0}}, shifted};
            opb = {{(UW-RW){1'b0}}, reload_ff};
         end
         ST_FIX: begin
            opa = {{(UW-RW){1'b0}}, reload_ff};
            opb = {{(UW-RW){1'b0}}, rem_ff};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign diff = opa - opb;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      reload_in    = reload_ff;
      enable_in    = enable_ff;
      pending_in   = pending_ff;
      dmask_in     = dmask_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      res_rd_in    = res_rd_ff;
      res_taken_in = res_taken_ff;
      res_vec_in   = res_vec_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_rd_in    = '0;
            res_taken_in = 1'b0;
            res_vec_in   = '0;
            state_in     = ST_DONE;
            case (op_ff)
               tic_pkg::OP_POLL: begin
                  state_in = ST_PICK;
                  if (enable_ff && count_ff[CW-1]) begin
                     pending_in[2] = 1'b1;
                     if (reload_ff != '0) begin
                        // new count is reload minus (-count mod reload)
                        dividend_in = diff[CW-1:0];
                        rem_in      = '0;
                        step_in     = 5'd31;
                        state_in    = ST_DIV;
                     end
                  end
               end
               tic_pkg::OP_ELAPSE: begin
                  // saturate below the signed minimum
                  if (diff[UW-1] && !(diff[CW] && diff[CW-1])) begin
                     count_in = {1'b1, {(CW-1){1'b0}}};
                  end else begin
                     count_in = diff[CW-1:0];
                  end
               end
               tic_pkg::OP_TIMER_WRITE: begin
                  if (!ofs_ff[0]) begin
                     reload_in = RW'(({1'b0, wdata_ff[6:0] & tic_pkg::LOAD_FIELD_MASK}
                                      + 8'd1)) << tic_pkg::LOAD_SHIFT;
                     count_in  = {{(CW-RW){1'b0}}, reload_in};
                  end else begin
                     enable_in = wdata_ff[0];
                  end
               end
               tic_pkg::OP_TIMER_READ: begin
                  res_rd_in = {1'b0, count_ff[tic_pkg::LOAD_SHIFT +: 7]};
               end
               tic_pkg::OP_IRQ_WRITE: begin
                  if (ofs_ff == tic_pkg::IRQ_OFS_MASK) begin
                     dmask_in = wdata_ff;
                  end else if (ofs_ff == tic_pkg::IRQ_OFS_PENDING) begin
                     pending_in[2] = 1'b0;
                  end
               end
               tic_pkg::OP_IRQ_READ: begin
                  if (ofs_ff == tic_pkg::IRQ_OFS_MASK) begin
                     res_rd_in = dmask_ff;
                  end else if (ofs_ff == tic_pkg::IRQ_OFS_PENDING) begin
                     res_rd_in = {5'd0, pending_ff};
                  end
               end
               tic_pkg::OP_LINE: begin
                  if (lidx_ff != tic_pkg::LINE_NONE) begin
                     pending_in[lidx_ff] = llev_ff;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit a cycle
            if (diff[UW-1]) begin
               rem_in = shifted[RW-1:0];
            end else begin
               rem_in = diff[RW-1:0];
            end
            dividend_in = {dividend_ff[CW-2:0], 1'b0};
            step_in     = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            count_in = {{(CW-RW){1'b0}}, diff[RW-1:0]};
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (!imask_ff && live != 3'd0) begin
               res_taken_in = 1'b1;
               if (live[0]) begin
                  res_vec_in = tic_pkg::VEC_SRC0;
               end else if (live[1]) begin
                  res_vec_in = tic_pkg::VEC_SRC1;
               end else begin
                  res_vec_in = tic_pkg::VEC_SRC2;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         reload_ff    <= '0;
         enable_ff    <= 1'b0;
         pending_ff   <= '0;
         dmask_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         enable_ff    <= enable_in;
         pending_ff   <= pending_in;
         dmask_ff     <= dmask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tuser;
         ofs_ff   <= req_tdata[1:0];
         wdata_ff <= req_tdata[9:2];
         cyc_ff   <= req_tdata[29:10];
         lidx_ff  <= req_tdata[31:30];
         llev_ff  <= req_tdata[32];
         imask_ff <= req_tdata[33];
      end
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      res_rd_ff    <= res_rd_in;
      res_taken_ff <= res_taken_in;
      res_vec_ff   <= res_vec_in;
      if (state_ff == ST_DONE && out_free) begin
         out_rd_ff    <= res_rd_ff;
         out_taken_ff <= res_taken_ff;
         out_vec_ff   <= res_vec_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_vec_ff, out_taken_ff, out_rd_ff};

   // remainder loop only runs with a nonzero reload and stays below it
   `TIC_ASSERT_IMPL(a_div_reload, clock, reset, state_ff == ST_DIV, reload_ff != '0)
   `TIC_ASSERT_IMPL(a_div_rem, clock, reset, state_ff == ST_DIV, rem_ff < reload_ff)
   // a reload leaves the counter strictly positive
   `TIC_ASSERT_NEXT(a_fix_pos, clock, reset, state_ff == ST_FIX,
                    !count_ff[CW-1] && count_ff != '0)
   // no vector address without a taken vector
   `TIC_ASSERT_IMPL(a_vec_zero, clock, reset, out_valid_ff && !out_taken_ff,
                    out_vec_ff == '0)

endmodule

@@ dv/timer_irq_controller_checker.sv @@
// ----------------------------------------------------------------------------
// timer_irq_controller_checker
// watches both item channels, predicts each response from an internal copy
// of the timer and interrupt state, and compares the responses field by field
// ----------------------------------------------------------------------------
module timer_irq_controller_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] vector_address;
      logic        vector_taken;
      logic [7:0]  read_data;
   } response_type;

   localparam int     RLD_W       = tic_pkg::RELOAD_W;
   localparam longint COUNT_FLOOR = -(longint'(1) << (tic_pkg::COUNT_W - 1));

   int                  countdown;
   logic [RLD_W-1:0]    reload;
   logic                timer_on;
   logic [2:0]          pending;
   logic [7:0]          irq_disable;
   response_type        response_q[$];

   // underflowed timer raises source 2 and is pulled back above zero
   function automatic void service_countdown();
      longint c, r, n;
      if (timer_on && countdown < 0) begin
         pending[2] = 1'b1;
         if (reload != '0) begin
            c = countdown;
            r = reload;
            n = (-c) / r + 1;
            countdown = int'(c + n * r);
         end
      end
   endfunction

   function automatic response_type next_response(logic [2:0] op, logic [39:0] fields);
      logic [1:0]   offs;
      logic [7:0]   data;
      logic [19:0]  cyc;
      logic [1:0]   lidx;
      logic         llev;
      logic         imask;
      logic [2:0]   live;
      longint       diff;
      int           load;
      response_type rsp;
      rsp   = '0;
      offs  = fields[1:0];
      data  = fields[9:2];
      cyc   = fields[29:10];
      lidx  = fields[31:30];
      llev  = fields[32];
      imask = fields[33];
      case (op)
         tic_pkg::OP_POLL: begin
            service_countdown();
            live = pending & ~irq_disable[2:0];
            if (!imask && live != '0) begin
               rsp.vector_taken = 1'b1;
               if (live[0])
                  rsp.vector_address = tic_pkg::VEC_SRC0;
               else if (live[1])
                  rsp.vector_address = tic_pkg::VEC_SRC1;
               else
                  rsp.vector_address = tic_pkg::VEC_SRC2;
            end
         end
         tic_pkg::OP_ELAPSE: begin
            diff = longint'(countdown) - longint'(cyc);
            if (diff < COUNT_FLOOR)
               diff = COUNT_FLOOR;
            countdown = int'(diff);
         end
         tic_pkg::OP_TIMER_WRITE: begin
            if (!offs[0]) begin
               load      = (int'(data) & int'(tic_pkg::LOAD_FIELD_MASK)) + 1;
               reload    = RLD_W'(load << tic_pkg::LOAD_SHIFT);
               countdown = int'(reload);
            end else begin
               timer_on = data[0];
            end
         end
         tic_pkg::OP_TIMER_READ:
            rsp.read_data = 8'((countdown >>> tic_pkg::LOAD_SHIFT)
                               & int'(tic_pkg::LOAD_FIELD_MASK));
         tic_pkg::OP_IRQ_WRITE: begin
            if (offs == tic_pkg::IRQ_OFS_MASK)
               irq_disable = data;
            else if (offs == tic_pkg::IRQ_OFS_PENDING)
               pending[2] = 1'b0;
         end
         tic_pkg::OP_IRQ_READ: begin
            if (offs == tic_pkg::IRQ_OFS_MASK)
               rsp.read_data = irq_disable;
            else if (offs == tic_pkg::IRQ_OFS_PENDING)
               rsp.read_data = {5'b0, pending};
         end
         tic_pkg::OP_LINE: begin
            if (lidx != tic_pkg::LINE_NONE)
               pending[lidx] = llev;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin : watch
      response_type expected;
      response_type actual;
      if (reset) begin
         countdown   = 0;
         reload      = '0;
         timer_on    = 1'b0;
         pending     = '0;
         irq_disable = '0;
         response_q.delete();
      end else begin
         // responses first, so an item accepted this edge cannot match
         if (rsp_tvalid && rsp_tready) begin
            actual = response_type'(rsp_tdata[24:0]);
            if (response_q.size() == 0) begin
               $error("response with no item outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               expected = response_q.pop_front();
               if (actual.read_data !== expected.read_data) begin
                  $error("read_data: expected %h, got %h",
                         expected.read_data, actual.read_data);
                  mismatch_count++;
               end
               if (actual.vector_taken !== expected.vector_taken) begin
                  $error("vector_taken: expected %b, got %b",
                         expected.vector_taken, actual.vector_taken);
                  mismatch_count++;
               end
               if (actual.vector_address !== expected.vector_address) begin
                  $error("vector_address: expected %h, got %h",
                         expected.vector_address, actual.vector_address);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            response_q.push_back(next_response(req_tuser, req_tdata));
      end
      outstanding <= response_q.size();
   end

endmodule

@@ dv/tb_timer_irq_controller.sv @@
// ----------------------------------------------------------------------------
// tb_timer_irq_controller
// drives directed and random items into the timer irq controller under
// changing idle patterns on both channels; the checker scores every response
// ----------------------------------------------------------------------------
module tb_timer_irq_controller;
   timeunit 1ns;
   timeprecision 1ps;

   // op code with no function in the block
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // timer register offsets, decoded by bit 0 only
   localparam logic [1:0] TIMER_OFS_LOAD      = 2'd0;
   localparam logic [1:0] TIMER_OFS_ENABLE    = 2'd1;
   localparam logic [1:0] TIMER_OFS_LOAD_HI   = 2'd2;
   localparam logic [1:0] TIMER_OFS_ENABLE_HI = 2'd3;
   // irq register offsets with no function
   localparam logic [1:0] IRQ_OFS_DEAD0 = 2'd0;
   localparam logic [1:0] IRQ_OFS_DEAD1 = 2'd1;

   // watchdog bound for ~460 items with long stalls
   localparam int CYCLE_LIMIT     = 100000;
   // longest item is a poll with reload
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 135;
   // elapses of the largest cycle count for a deep underflow
   localparam int DEEP_RUN        = 24;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [2:0] op
   logic [2:0]  req_tuser  = '0;
   // [1:0] reg_offset, [9:2] write_data, [29:10] elapsed_cycles,
   // [31:30] line_index, [32] line_level, [33] interrupt_mask, rest zero
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] read_data, [8] vector_taken, [24:9] vector_address, rest zero
   logic [31:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int gap_pct     = 24;
   int stall_pct   = 57;
   int cycle_count = 0;
   int sent        = 0;

   timer_irq_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   timer_irq_controller_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timer_irq_controller regression: fail");
         $finish;
      end
   end

   // presents one item and holds it until accepted; valid only drops for a gap
   task automatic send_item(input logic [2:0] op, input logic [1:0] offs,
                            input logic [7:0] data, input logic [19:0] cyc,
                            input logic [1:0] lidx, input logic llev,
                            input logic imask);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, imask, llev, lidx, cyc, data, offs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // mostly timer scenarios built around a poll and a readback, the rest unconstrained noise
   task automatic run_random(input int count);
      int          target;
      logic [19:0] cyc;
      target = sent + count;
      while (sent < target) begin
         if ($urandom_range(0, 9) < 6) begin
            if ($urandom_range(0, 3) != 0)
               send_item(tic_pkg::OP_TIMER_WRITE, {1'($urandom), 1'b0}, 8'($urandom),
                         '0, '0, 0, 0);
            if ($urandom_range(0, 3) != 0)
               send_item(tic_pkg::OP_TIMER_WRITE, {1'($urandom), 1'b1},
                         {7'($urandom), 1'($urandom_range(0, 5) != 0)}, '0, '0, 0, 0);
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 2))
                  0:       cyc = 20'($urandom_range(0, 2047));
                  1:       cyc = 20'($urandom_range(0, 1 << 17));
                  default: cyc = 20'($urandom);
               endcase
               send_item(tic_pkg::OP_ELAPSE, '0, '0, cyc, '0, 0, 0);
            end
            if ($urandom_range(0, 2) == 0)
               send_item(tic_pkg::OP_LINE, '0, '0, '0, 2'($urandom_range(0, 2)),
                         1'($urandom), 0);
            // keep the low mask bits sparse so vectors stay reachable
            if ($urandom_range(0, 4) == 0)
               send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_MASK,
                         {5'($urandom), 3'($urandom_range(0, 3) == 0 ? $urandom : 0)},
                         '0, '0, 0, 0);
            send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
               send_item(tic_pkg::OP_IRQ_READ, tic_pkg::IRQ_OFS_PENDING, '0, '0, '0, 0, 0);
            else
               send_item(tic_pkg::OP_TIMER_READ, '0, '0, '0, '0, 0, 0);
            if ($urandom_range(0, 2) == 0)
               send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_PENDING, '0, '0, '0, 0, 0);
         end else begin
            send_item(3'($urandom), 2'($urandom), 8'($urandom), 20'($urandom),
                      2'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part: timer enabled with reload still zero, underflow flags only
      send_item(tic_pkg::OP_IRQ_READ, tic_pkg::IRQ_OFS_PENDING, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_WRITE, TIMER_OFS_ENABLE, 8'h01, '0, '0, 0, 0);
      send_item(tic_pkg::OP_ELAPSE, '0, '0, 20'd1, '0, 0, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_READ, tic_pkg::IRQ_OFS_PENDING, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_READ, TIMER_OFS_ENABLE_HI, '0, '0, '0, 0, 0);
      // all three sources pending, then masked and priority polls
      send_item(tic_pkg::OP_LINE, '0, '0, '0, 2'd0, 1, 0);
      send_item(tic_pkg::OP_LINE, '0, '0, '0, 2'd1, 1, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 1);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_MASK, 8'hFF, '0, '0, 0, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_MASK, 8'h01, '0, '0, 0, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      // unused line index, timer ack, dead irq offsets
      send_item(tic_pkg::OP_LINE, '0, '0, '0, tic_pkg::LINE_NONE, 1, 0);
      send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_PENDING, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_WRITE, IRQ_OFS_DEAD0, 8'hFF, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_READ, IRQ_OFS_DEAD1, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_IRQ_READ, tic_pkg::IRQ_OFS_MASK, '0, '0, '0, 0, 0);
      // largest and smallest load, then a deep underflow and reload
      send_item(tic_pkg::OP_TIMER_WRITE, TIMER_OFS_LOAD, 8'hFF, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_READ, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_WRITE, TIMER_OFS_LOAD_HI, 8'h80, '0, '0, 0, 0);
      send_item(tic_pkg::OP_ELAPSE, '0, '0, 20'hFFFFF, '0, 0, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      send_item(OP_UNUSED, 2'h3, 8'hFF, 20'hFFFFF, 2'h3, 1, 1);
      send_item(tic_pkg::OP_IRQ_WRITE, tic_pkg::IRQ_OFS_MASK, 8'h00, '0, '0, 0, 0);

      run_random(ITEMS_PER_PHASE);

      gap_pct = 57;
      stall_pct <= 24;
      run_random(ITEMS_PER_PHASE);

      gap_pct = 0;
      stall_pct <= 0;
      // timer off, counter driven far below zero, then serviced
      send_item(tic_pkg::OP_TIMER_WRITE, TIMER_OFS_ENABLE, 8'h00, '0, '0, 0, 0);
      repeat (DEEP_RUN) send_item(tic_pkg::OP_ELAPSE, '0, '0, 20'hFFFFF, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_READ, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_WRITE, TIMER_OFS_ENABLE, 8'h01, '0, '0, 0, 0);
      send_item(tic_pkg::OP_POLL, '0, '0, '0, '0, 0, 0);
      send_item(tic_pkg::OP_TIMER_READ, '0, '0, '0, '0, 0, 0);
      run_random(ITEMS_PER_PHASE);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("timer_irq_controller regression: pass");
      else
         $display("timer_irq_controller regression: fail");
      $finish;
   end

endmodule
